// ----- rtl/nnis_pkg.sv -----
// ----------------------------------------------------------------------------
// nnis_pkg
// Shared types and constants of the nearest-neighbor image scaler.
// ----------------------------------------------------------------------------
package nnis_pkg;

    // Field widths fixed by the interface
    localparam int POS_W   = 16;
    localparam int PIX_W   = 8;
    localparam int SRCW_W  = 9;
    localparam int SRCH_W  = 8;
    localparam int ZOOM_W  = 16;
    localparam int DIM_W   = 16;
    localparam int FRAC_W  = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Clamped source dimension, wide enough for the largest frame size
    localparam int GDIM_W  = 11;

    // Default frame limits
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 128;

    // Register reset values
    localparam logic [SRCW_W-1:0] RST_SOURCE_WIDTH  = SRCW_W'(188);
    localparam logic [SRCH_W-1:0] RST_SOURCE_HEIGHT = SRCH_W'(120);
    localparam logic [ZOOM_W-1:0] RST_ZOOM          = ZOOM_W'(256);

    localparam logic [DIM_W-1:0]  DIM_SAT = '1;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_READ  = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_WIDTH  = 2'd0,
        CFG_SOURCE_HEIGHT = 2'd1,
        CFG_ZOOM          = 2'd2
    } t_cfg_idx;

    // Geometry derived from the registers
    typedef struct packed {
        logic [GDIM_W-1:0] w;
        logic [GDIM_W-1:0] h;
        logic [ZOOM_W-1:0] zoom;
        logic [DIM_W-1:0]  scaled_w;
        logic [DIM_W-1:0]  scaled_h;
    } t_geom;

    // Per-item control carried down the pipeline
    typedef struct packed {
        t_cmd             cmd;
        logic [PIX_W-1:0] pix;
        logic             wr_ok;
        logic             rd_ok;
    } t_side;

endpackage

// ----- rtl/nnis_cfg.sv -----
// ----------------------------------------------------------------------------
// nnis_cfg
// Configuration registers and the frame geometry derived from them.
// ----------------------------------------------------------------------------
module nnis_cfg #(
    parameter int MAX_WIDTH  = nnis_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = nnis_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [nnis_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [nnis_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output nnis_pkg::t_geom                     o_geom
);
    import nnis_pkg::*;

    localparam int PW = GDIM_W + ZOOM_W;

    logic [SRCW_W-1:0] r_source_width;
    logic [SRCH_W-1:0] r_source_height;
    logic [ZOOM_W-1:0] r_zoom;
    t_geom             r_geom;
    t_geom             n_geom;

    logic [GDIM_W-1:0] w_w;
    logic [GDIM_W-1:0] w_h;
    logic [ZOOM_W-1:0] w_z;
    logic [PW-1:0]     w_prod_w;
    logic [PW-1:0]     w_prod_h;
    logic [PW-1:0]     w_sum_w;
    logic [PW-1:0]     w_sum_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_width  <= RST_SOURCE_WIDTH;
            r_source_height <= RST_SOURCE_HEIGHT;
            r_zoom          <= RST_ZOOM;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SOURCE_WIDTH:  r_source_width  <= i_cfg_data[SRCW_W-1:0];
                CFG_SOURCE_HEIGHT: r_source_height <= i_cfg_data[SRCH_W-1:0];
                CFG_ZOOM:          r_zoom          <= i_cfg_data[ZOOM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        // zero means one, anything above the frame limit saturates
        if (r_source_width == '0) begin
            w_w = GDIM_W'(1);
        end else if (32'(r_source_width) > 32'(MAX_WIDTH)) begin
            w_w = GDIM_W'(MAX_WIDTH);
        end else begin
            w_w = GDIM_W'(r_source_width);
        end
        if (r_source_height == '0) begin
            w_h = GDIM_W'(1);
        end else if (32'(r_source_height) > 32'(MAX_HEIGHT)) begin
            w_h = GDIM_W'(MAX_HEIGHT);
        end else begin
            w_h = GDIM_W'(r_source_height);
        end
        w_z = (r_zoom == '0) ? ZOOM_W'(1) : r_zoom;

        w_prod_w = PW'(w_w - GDIM_W'(1)) * PW'(w_z);
        w_prod_h = PW'(w_h - GDIM_W'(1)) * PW'(w_z);
        w_sum_w  = (w_prod_w >> FRAC_W) + PW'(1);
        w_sum_h  = (w_prod_h >> FRAC_W) + PW'(1);

        n_geom.w        = w_w;
        n_geom.h        = w_h;
        n_geom.zoom     = w_z;
        n_geom.scaled_w = (w_sum_w > PW'(DIM_SAT)) ? DIM_SAT : w_sum_w[DIM_W-1:0];
        n_geom.scaled_h = (w_sum_h > PW'(DIM_SAT)) ? DIM_SAT : w_sum_h[DIM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_geom <= n_geom;
    end

    assign o_geom = r_geom;

endmodule

// ----- rtl/nnis_div.sv -----
// ----------------------------------------------------------------------------
// nnis_div
// Pipelined restoring divider: one quotient bit per axis in each stage.
// ----------------------------------------------------------------------------
module nnis_div #(
    parameter int QN = 8,
    parameter int RW = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [RW-1:0]                i_rem_x,
    input  logic [RW-1:0]                i_rem_y,
    input  logic [QN-1:0]                i_q_x,
    input  logic [QN-1:0]                i_q_y,
    input  nnis_pkg::t_side              i_side,
    input  logic [nnis_pkg::ZOOM_W-1:0]  i_zoom,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [QN-1:0]                o_q_x,
    output logic [QN-1:0]                o_q_y,
    output nnis_pkg::t_side              o_side
);
    import nnis_pkg::*;

    logic              r_v    [QN];
    logic [RW-1:0]     r_rx   [QN];
    logic [RW-1:0]     r_ry   [QN];
    logic [QN-1:0]     r_qx   [QN];
    logic [QN-1:0]     r_qy   [QN];
    t_side             r_side [QN];
    logic              w_ready [QN+1];

    assign w_ready[QN] = i_ready;

    for (genvar k = 0; k < QN; k++) begin : g_stage
        localparam int B = QN - 1 - k;

        logic          w_pv;
        logic [RW-1:0] w_prx;
        logic [RW-1:0] w_pry;
        logic [QN-1:0] w_pqx;
        logic [QN-1:0] w_pqy;
        t_side         w_pside;
        logic [RW-1:0] w_dz;
        logic          w_ge_x;
        logic          w_ge_y;
        logic [RW-1:0] n_rx;
        logic [RW-1:0] n_ry;
        logic [QN-1:0] n_qx;
        logic [QN-1:0] n_qy;

        if (k == 0) begin : g_first
            assign w_pv    = i_valid;
            assign w_prx   = i_rem_x;
            assign w_pry   = i_rem_y;
            assign w_pqx   = i_q_x;
            assign w_pqy   = i_q_y;
            assign w_pside = i_side;
        end else begin : g_next
            assign w_pv    = r_v[k-1];
            assign w_prx   = r_rx[k-1];
            assign w_pry   = r_ry[k-1];
            assign w_pqx   = r_qx[k-1];
            assign w_pqy   = r_qy[k-1];
            assign w_pside = r_side[k-1];
        end

        assign w_ready[k] = !r_v[k] || w_ready[k+1];

        always_comb begin
            w_dz   = RW'(i_zoom) << B;
            w_ge_x = (w_prx >= w_dz);
            w_ge_y = (w_pry >= w_dz);
            n_rx   = w_ge_x ? (w_prx - w_dz) : w_prx;
            n_ry   = w_ge_y ? (w_pry - w_dz) : w_pry;
            // writes keep their source coordinate in the quotient field
            n_qx   = w_pqx;
            n_qy   = w_pqy;
            if (w_pside.cmd == CMD_READ) begin
                n_qx[B] = w_ge_x;
                n_qy[B] = w_ge_y;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_ready[k]) begin
                r_v[k] <= w_pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_ready[k] && w_pv) begin
                r_rx[k]   <= n_rx;
                r_ry[k]   <= n_ry;
                r_qx[k]   <= n_qx;
                r_qy[k]   <= n_qy;
                r_side[k] <= w_pside;
            end
        end
    end

    assign o_ready = w_ready[0];
    assign o_valid = r_v[QN-1];
    assign o_q_x   = r_qx[QN-1];
    assign o_q_y   = r_qy[QN-1];
    assign o_side  = r_side[QN-1];

endmodule

// ----- rtl/nnis_mem.sv -----
// ----------------------------------------------------------------------------
// nnis_mem
// Address stage, source frame memory and the registered result stage.
// ----------------------------------------------------------------------------
module nnis_mem #(
    parameter int MAX_WIDTH  = nnis_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = nnis_pkg::DEF_MAX_HEIGHT,
    parameter int QX         = 8,
    parameter int QY         = 7
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [QX-1:0]                 i_q_x,
    input  logic [QY-1:0]                 i_q_y,
    input  nnis_pkg::t_side               i_side,
    input  logic [nnis_pkg::GDIM_W-1:0]   i_w,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [nnis_pkg::PIX_W-1:0]    o_pixel_out,
    output logic                          o_in_range
);
    import nnis_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int MW    = GDIM_W + QY + 1;

    logic             r_b_v;
    logic [AW-1:0]    r_b_addr;
    t_side            r_b_side;
    logic             r_c_v;
    t_side            r_c_side;
    logic [PIX_W-1:0] r_c_data;
    logic [PIX_W-1:0] r_mem [DEPTH];

    logic [MW-1:0]    n_b_addr;
    logic             w_ready_b;
    logic             w_ready_c;
    logic             w_adv_c;
    logic             w_mem_we;

    assign w_ready_c = !r_c_v || !i_stall;
    assign w_ready_b = !r_b_v || w_ready_c;
    assign w_adv_c   = r_b_v && w_ready_c;
    assign w_mem_we  = w_adv_c && (r_b_side.cmd == CMD_WRITE) && r_b_side.wr_ok;
    assign o_ready   = w_ready_b;

    // row-major address x + w*y
    assign n_b_addr = MW'(i_w) * MW'(i_q_y) + MW'(i_q_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else begin
            if (w_ready_b) begin
                r_b_v <= i_valid;
            end
            if (w_ready_c) begin
                r_c_v <= r_b_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_b && i_valid) begin
            r_b_addr <= n_b_addr[AW-1:0];
            r_b_side <= i_side;
        end
        if (w_adv_c) begin
            r_c_side <= r_b_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_b_addr] <= r_b_side.pix;
        end else if (w_adv_c) begin
            r_c_data <= r_mem[r_b_addr];
        end
    end

    assign o_valid     = r_c_v;
    assign o_in_range  = (r_c_side.cmd == CMD_WRITE) ? r_c_side.wr_ok : r_c_side.rd_ok;
    assign o_pixel_out = ((r_c_side.cmd == CMD_READ) && r_c_side.rd_ok) ? r_c_data : '0;

`ifndef SYNTHESIS
    a_we_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> (32'(r_b_addr) < 32'(DEPTH)))
        else $error("frame write outside the memory");

    a_b_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_v && !w_adv_c) |=> (r_b_v && $stable(r_b_addr) && $stable(r_b_side)))
        else $error("address stage lost or changed a stalled item");

    a_c_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_v && i_stall) |=> ($stable(o_pixel_out) && $stable(r_c_side)))
        else $error("result stage changed while stalled");
`endif

endmodule

// ----- rtl/nearest_neighbour_image_scaler_core.sv -----
// ----------------------------------------------------------------------------
// nearest_neighbour_image_scaler_core
// Grayscale frame store with nearest-neighbor scaled read-out.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+-------------------------------
//   command  | in        | i_valid / o_stall   | command, pos_x, pos_y, pixel_in
//   result   | out       | o_valid / i_stall   | pixel_out, in_range,
//            |           |                     | scaled_width, scaled_height
//   config   | in        | i_cfg_wr_en         | cfg_index, cfg_data
//
// One item per clock sustained while the result side does not stall. Items
// pass an input register, QN divider stages, QN being the quotient bits of
// the divider (8 at the default frame limits), an address stage and the
// memory read register, in that order. Each divider stage retires one
// quotient bit per axis.
// Reset is synchronous, active low; it clears the valid bits and restores the
// registers, the frame memory is left as is. A stall on the result side only
// backs up stages that hold an item; bubbles ahead of it still fill.
// ----------------------------------------------------------------------------
module nearest_neighbour_image_scaler_core #(
    parameter int MAX_WIDTH  = nnis_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = nnis_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_wr_en,
    input  logic [nnis_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [nnis_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // command items
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_command,
    input  logic [nnis_pkg::POS_W-1:0]        i_pos_x,
    input  logic [nnis_pkg::POS_W-1:0]        i_pos_y,
    input  logic [nnis_pkg::PIX_W-1:0]        i_pixel_in,
    // result items
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [nnis_pkg::PIX_W-1:0]        o_pixel_out,
    output logic                              o_in_range,
    output logic [nnis_pkg::DIM_W-1:0]        o_scaled_width,
    output logic [nnis_pkg::DIM_W-1:0]        o_scaled_height
);
    import nnis_pkg::*;

    // Source coordinates never exceed the frame limits, so the quotient
    // needs only as many bits as the larger limit.
    localparam int QX = $clog2(MAX_WIDTH);
    localparam int QY = $clog2(MAX_HEIGHT);
    localparam int QN = (QX > QY) ? QX : QY;
    localparam int DW = POS_W + FRAC_W;
    localparam int RW = (POS_W + QN > DW) ? POS_W + QN : DW;

    t_geom            w_geom;

    // input register
    logic             r_a_v;
    t_cmd             r_a_cmd;
    logic [POS_W-1:0] r_a_x;
    logic [POS_W-1:0] r_a_y;
    logic [PIX_W-1:0] r_a_pix;
    logic             w_ready_a;

    // divider hookup
    logic             w_div_ready;
    logic [RW-1:0]    w_rem_x;
    logic [RW-1:0]    w_rem_y;
    t_side            w_a_side;
    logic             w_div_valid;
    logic [QN-1:0]    w_q_x;
    logic [QN-1:0]    w_q_y;
    t_side            w_div_side;
    logic             w_mem_ready;

    nnis_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_geom      (w_geom)
    );

    // Take a new item whenever the input register is empty or moves on.
    assign w_ready_a = !r_a_v || w_div_ready;
    assign o_stall   = !w_ready_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (w_ready_a) begin
            r_a_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_a && i_valid) begin
            r_a_cmd <= t_cmd'(i_command);
            r_a_x   <= i_pos_x;
            r_a_y   <= i_pos_y;
            r_a_pix <= i_pixel_in;
        end
    end

    // Range checks. A read inside the scaled frame always maps inside the
    // source, so the output-side check alone decides in_range for reads.
    always_comb begin
        w_a_side.cmd   = r_a_cmd;
        w_a_side.pix   = r_a_pix;
        w_a_side.wr_ok = (r_a_x < POS_W'(w_geom.w)) && (r_a_y < POS_W'(w_geom.h));
        w_a_side.rd_ok = (r_a_x < w_geom.scaled_w) && (r_a_y < w_geom.scaled_h);
        // dividend is coordinate * 256
        w_rem_x = RW'({r_a_x, {FRAC_W{1'b0}}});
        w_rem_y = RW'({r_a_y, {FRAC_W{1'b0}}});
    end

    nnis_div #(
        .QN (QN),
        .RW (RW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_a_v),
        .o_ready (w_div_ready),
        .i_rem_x (w_rem_x),
        .i_rem_y (w_rem_y),
        .i_q_x   (r_a_x[QN-1:0]),
        .i_q_y   (r_a_y[QN-1:0]),
        .i_side  (w_a_side),
        .i_zoom  (w_geom.zoom),
        .o_valid (w_div_valid),
        .i_ready (w_mem_ready),
        .o_q_x   (w_q_x),
        .o_q_y   (w_q_y),
        .o_side  (w_div_side)
    );

    nnis_mem #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .QX         (QX),
        .QY         (QY)
    ) u_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_div_valid),
        .o_ready     (w_mem_ready),
        .i_q_x       (w_q_x[QX-1:0]),
        .i_q_y       (w_q_y[QY-1:0]),
        .i_side      (w_div_side),
        .i_w         (w_geom.w),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_pixel_out (o_pixel_out),
        .o_in_range  (o_in_range)
    );

    // The user changes geometry only while no item is in flight; report as is.
    assign o_scaled_width  = w_geom.scaled_w;
    assign o_scaled_height = w_geom.scaled_h;

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the nearest-neighbor image scaler core.
//
// A queue of pending commands feeds a falling-edge driver that sends items
// in bursts with random gaps. Every accepted item is run through a local
// copy of the frame store and the scaling arithmetic. The expected result
// is queued and then compared, field by field, with what the core returns.
// The result side stalls on a windowed pattern of its own and holds off
// once for a long stretch, so the pipeline fills and stalls its input.
// Reads are only aimed at source pixels that an earlier write has filled.
// Writes are added on the fly wherever a read would land on a pixel that
// was never written.
// ----------------------------------------------------------------------------
module tb_top;
    import nnis_pkg::*;

    localparam int MAX_W           = DEF_MAX_WIDTH;
    localparam int MAX_H           = DEF_MAX_HEIGHT;
    localparam int FRAME_DEPTH     = MAX_W * MAX_H;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 170;
    // with margin over the path from acceptance to a result
    localparam int DRAIN_CYCLES    = 32;
    localparam int LONG_HOLD       = 300;
    localparam int CYCLE_LIMIT     = 400000;

    typedef struct packed {
        t_cmd             cmd;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [PIX_W-1:0] pix;
    } t_pixel_cmd;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             in_range;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } t_pixel_result;

    // ------------------------------------------------------------------------
    // Signals, the bench-driven ones known from time zero
    // ------------------------------------------------------------------------
    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                  i_valid         = 1'b0;
    logic                  o_stall;
    logic                  i_command       = 1'b0;
    logic [POS_W-1:0]      i_pos_x         = '0;
    logic [POS_W-1:0]      i_pos_y         = '0;
    logic [PIX_W-1:0]      i_pixel_in      = '0;
    logic                  o_valid;
    logic                  i_stall         = 1'b0;
    logic [PIX_W-1:0]      o_pixel_out;
    logic                  o_in_range;
    logic [DIM_W-1:0]      o_scaled_width;
    logic [DIM_W-1:0]      o_scaled_height;

    nearest_neighbour_image_scaler_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_command       (i_command),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_pixel_in      (i_pixel_in),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_pixel_out     (o_pixel_out),
        .o_in_range      (o_in_range),
        .o_scaled_width  (o_scaled_width),
        .o_scaled_height (o_scaled_height)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    // register copies, masked to their widths the way the core stores them
    logic [SRCW_W-1:0] shadow_width  = RST_SOURCE_WIDTH;
    logic [SRCH_W-1:0] shadow_height = RST_SOURCE_HEIGHT;
    logic [ZOOM_W-1:0] shadow_zoom   = RST_ZOOM;

    logic [PIX_W-1:0]  frame_copy   [0:FRAME_DEPTH-1];
    // pixels that some queued write will have filled; flat index, so it
    // stays valid across a change of width
    bit                frame_filled [0:FRAME_DEPTH-1];

    t_pixel_cmd        command_q[$];
    t_pixel_result     pending_results[$];

    bit                item_taken  = 1'b0;
    bit                failed      = 1'b0;
    int unsigned       n_accepted  = 0;
    int unsigned       cycle_count = 0;
    int unsigned       gap_left    = 0;
    int unsigned       burst_left  = 0;
    int unsigned       hold_left   = 0;
    int unsigned       window_left = 0;
    int unsigned       stall_mode  = 0;
    bit                long_hold_done = 1'b0;

    // ------------------------------------------------------------------------
    // Geometry and prediction
    // ------------------------------------------------------------------------
    // zero counts as one, anything above the store is saturated
    function automatic int unsigned clamp_size(int unsigned v, int unsigned limit);
        if (v == 0) return 1;
        return (v > limit) ? limit : v;
    endfunction

    function automatic int unsigned frame_w();
        return clamp_size(shadow_width, MAX_W);
    endfunction

    function automatic int unsigned frame_h();
        return clamp_size(shadow_height, MAX_H);
    endfunction

    // zoom of zero behaves as the smallest step, 1/256
    function automatic int unsigned zoom_factor();
        return (shadow_zoom == '0) ? 1 : int'(shadow_zoom);
    endfunction

    function automatic int unsigned scaled_size(int unsigned dim);
        longint unsigned s;
        s = ((longint'(dim - 1) * zoom_factor()) >> FRAC_W) + 1;
        return (s > 65535) ? 65535 : int'(s);
    endfunction

    // output coordinate back to the source: floor(c * 256 / zoom)
    function automatic int unsigned to_source(logic [POS_W-1:0] coord);
        int unsigned c;
        c = coord;
        return (c << FRAC_W) / zoom_factor();
    endfunction

    // Update the frame copy for a write and work out the result item
    function automatic t_pixel_result predict_result(t_pixel_cmd c);
        int unsigned   w;
        int unsigned   h;
        int unsigned   sx;
        int unsigned   sy;
        t_pixel_result r;
        w        = frame_w();
        h        = frame_h();
        r        = '0;
        r.width  = DIM_W'(scaled_size(w));
        r.height = DIM_W'(scaled_size(h));
        if (c.cmd == CMD_WRITE) begin
            if (c.x < w && c.y < h) begin
                frame_copy[c.x + w * c.y] = c.pix;
                r.in_range = 1'b1;
            end
        end else if (c.x < r.width && c.y < r.height) begin
            sx = to_source(c.x);
            sy = to_source(c.y);
            if (sx < w && sy < h) begin
                r.pixel    = frame_copy[sx + w * sy];
                r.in_range = 1'b1;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_write(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                               logic [PIX_W-1:0] pix);
        int unsigned w;
        int unsigned h;
        w = frame_w();
        h = frame_h();
        if (x < w && y < h) frame_filled[x + w * y] = 1'b1;
        command_q.push_back('{cmd: CMD_WRITE, x: x, y: y, pix: pix});
    endtask

    // Fill the target pixel first if the read would land on an empty one
    task automatic queue_read(logic [POS_W-1:0] x, logic [POS_W-1:0] y);
        int unsigned w;
        int unsigned h;
        int unsigned sx;
        int unsigned sy;
        w = frame_w();
        h = frame_h();
        if (x < scaled_size(w) && y < scaled_size(h)) begin
            sx = to_source(x);
            sy = to_source(y);
            if (sx < w && sy < h && !frame_filled[sx + w * sy])
                queue_write(POS_W'(sx), POS_W'(sy), PIX_W'($urandom()));
        end
        command_q.push_back('{cmd: CMD_READ, x: x, y: y, pix: PIX_W'($urandom())});
    endtask

    // Mostly in-frame writes and in-frame reads, plus strays anywhere
    task automatic queue_random_item();
        int unsigned w;
        int unsigned h;
        int unsigned sw;
        int unsigned sh;
        int unsigned pick;
        w    = frame_w();
        h    = frame_h();
        sw   = scaled_size(w);
        sh   = scaled_size(h);
        pick = $urandom_range(0, 99);
        if (pick < 40)
            queue_write(POS_W'($urandom_range(0, w - 1)), POS_W'($urandom_range(0, h - 1)),
                        PIX_W'($urandom()));
        else if (pick < 50)
            queue_write(POS_W'($urandom()), POS_W'($urandom()), PIX_W'($urandom()));
        else if (pick < 85)
            queue_read(POS_W'($urandom_range(0, sw - 1)), POS_W'($urandom_range(0, sh - 1)));
        else if (pick < 92)
            // just past the scaled edge on one axis
            if ($urandom_range(0, 1))
                queue_read(POS_W'(sw), POS_W'($urandom_range(0, sh - 1)));
            else
                queue_read(POS_W'($urandom_range(0, sw - 1)), POS_W'(sh));
        else
            queue_read(POS_W'($urandom()), POS_W'($urandom()));
    endtask

    // Only call with the core idle; the copy follows the write at once
    task automatic set_register(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_SOURCE_WIDTH:  shadow_width  = data[SRCW_W-1:0];
            CFG_SOURCE_HEIGHT: shadow_height = data[SRCH_W-1:0];
            CFG_ZOOM:          shadow_zoom   = data[ZOOM_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Every item yields a result, so an empty result queue means idle
    task automatic drain_results();
        @(posedge i_clk);
        while (command_q.size() != 0 || pending_results.size() != 0 || i_valid)
            @(posedge i_clk);
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
            failed = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Driver: present a new item once the last one is taken or the line is
    // idle; hold a stalled item as it is
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_pixel_cmd nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || item_taken) begin
            item_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                i_valid <= 1'b0;
            end else if (command_q.size() != 0) begin
                nxt = command_q.pop_front();
                i_valid    <= 1'b1;
                i_command  <= nxt.cmd;
                i_pos_x    <= nxt.x;
                i_pos_y    <= nxt.y;
                i_pixel_in <= nxt.pix;
                if (burst_left > 0) begin
                    burst_left = burst_left - 1;
                end else begin
                    // new burst; gaps are often zero, sometimes long
                    burst_left = $urandom_range(1, 30);
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: gap_left = 0;
                        9:          gap_left = $urandom_range(15, 40);
                        default:    gap_left = $urandom_range(1, 6);
                    endcase
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall pattern changes per window; hold off once for a long
    // stretch while plenty of items wait, so the core backs up
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        bit stall_now;
        stall_now = 1'b0;
        if (i_rst_n) begin
            if (!long_hold_done && n_accepted >= 400 && command_q.size() >= 60) begin
                hold_left      = LONG_HOLD;
                long_hold_done = 1'b1;
            end else if (hold_left == 0 && $urandom_range(0, 1999) == 0) begin
                hold_left = $urandom_range(40, 150);
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                stall_now = 1'b1;
            end else begin
                if (window_left == 0) begin
                    stall_mode  = $urandom_range(0, 3);
                    window_left = $urandom_range(16, 128);
                end
                window_left = window_left - 1;
                case (stall_mode)
                    0:       stall_now = 1'b0;
                    1:       stall_now = ($urandom_range(0, 3) == 0);
                    2:       stall_now = ($urandom_range(0, 9) < 7);
                    default: stall_now = ~i_stall;
                endcase
            end
        end
        i_stall <= stall_now;
    end

    // ------------------------------------------------------------------------
    // Rising edge: take accepted items into the predictor, check results,
    // count cycles
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pixel_cmd    taken;
        t_pixel_result want;
        t_pixel_result got;
        if (i_rst_n && i_valid && !o_stall) begin
            taken = '{cmd: t_cmd'(i_command), x: i_pos_x, y: i_pos_y, pix: i_pixel_in};
            pending_results.push_back(predict_result(taken));
            item_taken = 1'b1;
            n_accepted = n_accepted + 1;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_pixel_out, o_in_range, o_scaled_width, o_scaled_height};
            if (pending_results.size() == 0) begin
                $display("%0t ns: result with no item pending, pixel_out %0d in_range %0d",
                         $time, o_pixel_out, o_in_range);
                failed = 1'b1;
            end else begin
                want = pending_results.pop_front();
                check_field("pixel_out", want.pixel, got.pixel);
                check_field("in_range", want.in_range, got.in_range);
                check_field("scaled_width", want.width, got.width);
                check_field("scaled_height", want.height, got.height);
            end
        end
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, directed corners, then random phases
    // ------------------------------------------------------------------------
    initial begin
        logic [CFG_DATA_W-1:0] data;
        int unsigned           dim;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // default geometry 188 x 120, zoom 1.0: corners and strays
        queue_write(16'd0, 16'd0, 8'h00);
        queue_write(16'd187, 16'd119, 8'hFF);
        queue_write(16'd5, 16'd7, 8'h5A);
        queue_write(16'd188, 16'd0, 8'h11);
        queue_write(16'd0, 16'd120, 8'h22);
        queue_write(16'hFFFF, 16'hFFFF, 8'hA5);
        // hold the reads back until every write has come out
        drain_results();
        queue_read(16'd0, 16'd0);
        queue_read(16'd187, 16'd119);
        queue_read(16'd5, 16'd7);
        queue_read(16'd188, 16'd0);
        queue_read(16'd0, 16'd120);
        queue_read(16'hFFFF, 16'hFFFF);
        drain_results();

        // zero width, height and zoom; upper data bits must be dropped
        set_register(CFG_SOURCE_WIDTH, 16'hFE00);
        set_register(CFG_SOURCE_HEIGHT, 16'hFF00);
        set_register(CFG_ZOOM, 16'h0000);
        queue_read(16'd0, 16'd0);
        queue_read(16'd1, 16'd0);
        queue_read(16'd0, 16'd1);
        queue_write(16'd1, 16'd0, 8'h3C);
        queue_write(16'd0, 16'd0, 8'hC3);
        queue_read(16'd0, 16'd0);
        drain_results();

        // oversize width and height saturate; largest zoom
        set_register(CFG_SOURCE_WIDTH, 16'h01FF);
        set_register(CFG_SOURCE_HEIGHT, 16'h00FF);
        set_register(CFG_ZOOM, 16'hFFFF);
        queue_write(16'd255, 16'd127, 8'h81);
        queue_read(16'd65280, 16'd32511);
        queue_read(16'd65281, 16'd0);
        queue_read(16'd0, 16'd32512);
        queue_read(16'd0, 16'd0);
        drain_results();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(0, 5))
                0:       dim = $urandom_range(1, 8);
                1:       dim = $urandom_range(1, 256);
                2:       dim = 256;
                3:       dim = $urandom_range(257, 511);
                4:       dim = 188;
                default: dim = $urandom_range(1, 32);
            endcase
            data = CFG_DATA_W'($urandom());
            data[SRCW_W-1:0] = SRCW_W'(dim);
            set_register(CFG_SOURCE_WIDTH, data);

            case ($urandom_range(0, 5))
                0:       dim = $urandom_range(1, 8);
                1:       dim = $urandom_range(1, 128);
                2:       dim = 128;
                3:       dim = $urandom_range(129, 255);
                4:       dim = 120;
                default: dim = $urandom_range(1, 16);
            endcase
            data = CFG_DATA_W'($urandom());
            data[SRCH_W-1:0] = SRCH_W'(dim);
            set_register(CFG_SOURCE_HEIGHT, data);

            case ($urandom_range(0, 6))
                0:       data = CFG_DATA_W'($urandom_range(1, 255));
                1:       data = CFG_DATA_W'(256);
                2:       data = CFG_DATA_W'($urandom_range(257, 1024));
                3:       data = CFG_DATA_W'($urandom());
                4:       data = CFG_DATA_W'($urandom_range(64, 512));
                5:       data = CFG_DATA_W'(phase == 3 ? 0 : $urandom_range(1, 4));
                default: data = CFG_DATA_W'($urandom_range(1024, 65535));
            endcase
            set_register(CFG_ZOOM, data);

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                queue_random_item();
            drain_results();
        end

        // let any stray result show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failed)
            $display("Verification failed");
        else
            $display("Verification passed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/nnis_pkg.sv
rtl/nnis_cfg.sv
rtl/nnis_div.sv
rtl/nnis_mem.sv
rtl/nearest_neighbour_image_scaler_core.sv
test/tb_top.sv
